[rtl/cfd_pkg.sv]
`default_nettype none

package cfd_pkg;

   // Frame limits
   localparam int MAX_PAYLOAD = 32;
   localparam int STORE_DEPTH = 32;
   localparam int LEN_LIMIT   = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // CRC-8 constants
   localparam logic [7:0] CRC_POLY = 8'h07;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_FIRST_MAGIC    = 3'd0;
   localparam logic [2:0] CSR_SECOND_MAGIC   = 3'd1;
   localparam logic [2:0] CSR_VERSION_VALUE  = 3'd2;
   localparam logic [2:0] CSR_HEARTBEAT_KIND = 3'd3;

   // Register reset values
   localparam logic [7:0] RST_FIRST_MAGIC    = 8'd170;
   localparam logic [7:0] RST_SECOND_MAGIC   = 8'd85;
   localparam logic [7:0] RST_VERSION_VALUE  = 8'd1;
   localparam logic [7:0] RST_HEARTBEAT_KIND = 8'd0;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic crc_first;   // start the CRC from zero with this byte
      logic crc_upd;     // fold this byte into the running CRC
      logic type_load;   // capture the type byte
      logic len_load;    // capture the length byte, clear fill index
      logic store_wr;    // write a payload byte into the buffer
      logic rd_clr;      // restart the read-out index
      logic rd_en;       // read the buffer at the read-out index
      logic out_single;  // load a single marker or empty result
      logic out_byte;    // load a payload byte result
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic first_hit;
      logic second_hit;
      logic version_hit;
      logic len_over;
      logic len_zero;
      logic fill_done;
      logic crc_hit;
      logic hb_hit;
      logic held_len_zero;
      logic rd_last;
      logic out_free;
   } sts_type;

   // One MSB-first CRC-8 byte step
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

[rtl/crc8_frame_deframer_unit.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  rx_byte
// rsp_      out        rsp_valid/rsp_ready  frame_type .. last
// csr_      in         csr_we               csr_index, csr_wdata
//
// Header and payload bytes are taken one per cycle. A verified data frame
// is read out of the payload buffer a byte at a time (buffer read, then
// result load); requests are held off for the whole read-out. The CRC byte
// waits until the result register is free. Reset is synchronous and returns
// the parser to the magic hunt with the registers at their defaults; the
// payload buffer is not cleared. A stalled result holds its register.

module crc8_frame_deframer_unit
   import cfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_frame_type,
   output logic [5:0]      rsp_payload_length,
   output logic [4:0]      rsp_byte_index,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_has_byte,
   output logic            rsp_is_heartbeat,
   output logic            rsp_last
);

   cmd_type cmd;
   sts_type sts;

   cfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cfd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_rx_byte        (req_rx_byte),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_is_heartbeat   (rsp_is_heartbeat),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

[rtl/cfd_ctrl.sv]
`default_nettype none

module cfd_ctrl
   import cfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [3:0] ST_MAGIC0  = 4'd0;
   localparam logic [3:0] ST_MAGIC1  = 4'd1;
   localparam logic [3:0] ST_VERSION = 4'd2;
   localparam logic [3:0] ST_TYPE    = 4'd3;
   localparam logic [3:0] ST_SEQ     = 4'd4;
   localparam logic [3:0] ST_LENGTH  = 4'd5;
   localparam logic [3:0] ST_PAYLOAD = 4'd6;
   localparam logic [3:0] ST_CRC     = 4'd7;
   localparam logic [3:0] ST_EMIT_RD = 4'd8;
   localparam logic [3:0] ST_EMIT_LD = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       take;

   // Hold off requests during read-out, and at the CRC byte until the output is free
   always_comb begin
      unique case (state_ff)
         ST_EMIT_RD, ST_EMIT_LD: req_ready = 1'b0;
         ST_CRC:                 req_ready = sts.out_free;
         default:                req_ready = 1'b1;
      endcase
   end

   assign take = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_MAGIC0: begin
            if (take && sts.first_hit) state_in = ST_MAGIC1;
         end
         ST_MAGIC1: begin
            if (take) begin
               priority if (sts.second_hit) state_in = ST_VERSION;
               else if (sts.first_hit)      state_in = ST_MAGIC1;
               else                         state_in = ST_MAGIC0;
            end
         end
         ST_VERSION: begin
            if (take) begin
               if (sts.version_hit) begin
                  cmd.crc_first = 1'b1;
                  state_in      = ST_TYPE;
               end else begin
                  state_in = ST_MAGIC0;
               end
            end
         end
         ST_TYPE: begin
            if (take) begin
               cmd.type_load = 1'b1;
               cmd.crc_upd   = 1'b1;
               state_in      = ST_SEQ;
            end
         end
         ST_SEQ: begin
            if (take) begin
               cmd.crc_upd = 1'b1;
               state_in    = ST_LENGTH;
            end
         end
         ST_LENGTH: begin
            if (take) begin
               priority if (sts.len_over) begin
                  state_in = ST_MAGIC0;
               end else begin
                  cmd.len_load = 1'b1;
                  cmd.crc_upd  = 1'b1;
                  state_in     = sts.len_zero ? ST_CRC : ST_PAYLOAD;
               end
            end
         end
         ST_PAYLOAD: begin
            if (take) begin
               cmd.store_wr = 1'b1;
               cmd.crc_upd  = 1'b1;
               if (sts.fill_done) state_in = ST_CRC;
            end
         end
         ST_CRC: begin
            if (take) begin
               state_in = ST_MAGIC0;
               if (sts.crc_hit) begin
                  priority if (sts.hb_hit || sts.held_len_zero) begin
                     cmd.out_single = 1'b1;
                  end else begin
                     cmd.rd_clr = 1'b1;
                     state_in   = ST_EMIT_RD;
                  end
               end
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.out_byte = 1'b1;
               state_in     = sts.rd_last ? ST_MAGIC0 : ST_EMIT_RD;
            end
         end
         default: state_in = ST_MAGIC0;
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MAGIC0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/cfd_datapath.sv]
`default_nettype none

module cfd_datapath
   import cfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   input  wire logic [7:0] req_rx_byte,
   input  wire cmd_type    cmd,
   output sts_type         sts,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_frame_type,
   output logic [5:0]      rsp_payload_length,
   output logic [4:0]      rsp_byte_index,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_has_byte,
   output logic            rsp_is_heartbeat,
   output logic            rsp_last
);

   logic [7:0]        first_magic_ff;
   logic [7:0]        second_magic_ff;
   logic [7:0]        version_value_ff;
   logic [7:0]        heartbeat_kind_ff;
   logic [7:0]        held_type_ff;
   logic [5:0]        held_length_ff;
   logic [5:0]        fill_ff;
   logic [5:0]        fill_in;
   logic [7:0]        crc_ff;
   logic [7:0]        crc_base;
   logic [ADDR_W-1:0] rd_idx_ff;
   logic [7:0]        rd_data_ff;
   logic [7:0]        store_mem [STORE_DEPTH];
   logic              valid_ff;
   logic [7:0]        out_type_ff;
   logic [5:0]        out_len_ff;
   logic [4:0]        out_idx_ff;
   logic [7:0]        out_byte_ff;
   logic              out_has_ff;
   logic              out_hb_ff;
   logic              out_last_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_magic_ff    <= RST_FIRST_MAGIC;
         second_magic_ff   <= RST_SECOND_MAGIC;
         version_value_ff  <= RST_VERSION_VALUE;
         heartbeat_kind_ff <= RST_HEARTBEAT_KIND;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_MAGIC:    first_magic_ff    <= csr_wdata;
            CSR_SECOND_MAGIC:   second_magic_ff   <= csr_wdata;
            CSR_VERSION_VALUE:  version_value_ff  <= csr_wdata;
            CSR_HEARTBEAT_KIND: heartbeat_kind_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign fill_in  = fill_ff + 6'd1;
   assign crc_base = cmd.crc_first ? 8'd0 : crc_ff;

   // Header fields, fill index and running CRC
   always_ff @(posedge clock) begin
      if (cmd.type_load) held_type_ff <= req_rx_byte;
      if (cmd.len_load) begin
         held_length_ff <= req_rx_byte[5:0];
         fill_ff        <= '0;
      end else if (cmd.store_wr) begin
         fill_ff <= fill_in;
      end
      if (cmd.crc_first || cmd.crc_upd) crc_ff <= crc8_step(crc_base, req_rx_byte);
   end

   // Payload buffer
   always_ff @(posedge clock) begin
      if (cmd.store_wr) store_mem[fill_ff[ADDR_W-1:0]] <= req_rx_byte;
      if (cmd.rd_en) rd_data_ff <= store_mem[rd_idx_ff];
   end

   // Read-out index
   always_ff @(posedge clock) begin
      if (cmd.rd_clr) begin
         rd_idx_ff <= '0;
      end else if (cmd.out_byte) begin
         rd_idx_ff <= rd_idx_ff + ADDR_W'(1);
      end
   end

   // Result register: load on command, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_single || cmd.out_byte) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_single) begin
         out_type_ff <= held_type_ff;
         out_len_ff  <= held_length_ff;
         out_idx_ff  <= '0;
         out_byte_ff <= '0;
         out_has_ff  <= 1'b0;
         out_hb_ff   <= sts.hb_hit;
         out_last_ff <= 1'b1;
      end else if (cmd.out_byte) begin
         out_type_ff <= held_type_ff;
         out_len_ff  <= held_length_ff;
         out_idx_ff  <= 5'(rd_idx_ff);
         out_byte_ff <= rd_data_ff;
         out_has_ff  <= 1'b1;
         out_hb_ff   <= 1'b0;
         out_last_ff <= sts.rd_last;
      end
   end

   // Status to the controller
   always_comb begin
      sts.first_hit     = (req_rx_byte == first_magic_ff);
      sts.second_hit    = (req_rx_byte == second_magic_ff);
      sts.version_hit   = (req_rx_byte == version_value_ff);
      sts.len_over      = (req_rx_byte > 8'(LEN_LIMIT));
      sts.len_zero      = (req_rx_byte == 8'd0);
      sts.fill_done     = (fill_in >= held_length_ff);
      sts.crc_hit       = (req_rx_byte == crc_ff);
      sts.hb_hit        = (held_type_ff == heartbeat_kind_ff);
      sts.held_len_zero = (held_length_ff == 6'd0);
      sts.rd_last       = ((6'(rd_idx_ff) + 6'd1) == held_length_ff);
      sts.out_free      = !valid_ff || rsp_ready;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_frame_type     = out_type_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_byte_index     = out_idx_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_has_byte       = out_has_ff;
   assign rsp_is_heartbeat   = out_hb_ff;
   assign rsp_last           = out_last_ff;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import cfd_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 80;
   localparam int MAX_GAP       = 13;
   localparam int RANDOM_BYTES  = 30;
   localparam int CONFIG_SPAN   = 15;

   // Unused register slots on the csr port
   localparam logic [2:0] CSR_SPARE_LO = 3'd4;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic [2:0] {
      HUNT_FIRST,
      HUNT_SECOND,
      TAKE_VERSION,
      TAKE_TYPE,
      TAKE_SEQ,
      TAKE_LENGTH,
      TAKE_PAYLOAD,
      TAKE_CHECK
   } parse_phase_type;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_CRC,
      FRAME_BAD_VERSION,
      FRAME_OVERSIZE
   } frame_flaw_type;

   typedef struct packed {
      logic [7:0] frame_type;
      logic [5:0] payload_length;
      logic [4:0] byte_index;
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       is_heartbeat;
      logic       last;
   } frame_result_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_frame_type;
   logic [5:0] rsp_payload_length;
   logic [4:0] rsp_byte_index;
   logic [7:0] rsp_payload_byte;
   logic       rsp_has_byte;
   logic       rsp_is_heartbeat;
   logic       rsp_last;

   // Shadow of the register file
   logic [7:0] magic_a;
   logic [7:0] magic_b;
   logic [7:0] version_req;
   logic [7:0] heartbeat_type;

   // Shadow of the parser
   parse_phase_type parse_at;
   logic [7:0]      hold_type;
   logic [5:0]      hold_len;
   logic [5:0]      fill_count;
   logic [7:0]      crc_acc;
   logic [7:0]      payload_mem [STORE_DEPTH];

   frame_result_type frame_results_q[$];
   logic [7:0]       tx_bytes_q[$];
   frame_result_type seen_result;
   frame_result_type want_result;

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned rsp_stall_left = 0;
   int unsigned rsp_hold_left  = 0;
   int unsigned bytes_sent     = 0;
   bit          req_no_gap     = 1'b0;
   bit          rsp_no_stall   = 1'b0;

   crc8_frame_deframer_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_is_heartbeat   (rsp_is_heartbeat),
      .rsp_last           (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // MSB-first CRC-8, one input bit at a time
   function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] data);
      logic feedback;
      for (int k = 7; k >= 0; k--) begin
         feedback = acc[7] ^ data[k];
         acc = {acc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

   task automatic restart_parser();
      parse_at   = HUNT_FIRST;
      hold_type  = 8'h00;
      hold_len   = 6'd0;
      fill_count = 6'd0;
      crc_acc    = 8'h00;
   endtask

   // Advance the parser shadow by one accepted byte and queue what it yields
   task automatic parse_rx_byte(input logic [7:0] rx);
      frame_result_type r;
      r = '0;
      case (parse_at)
         HUNT_FIRST: begin
            if (rx == magic_a) parse_at = HUNT_SECOND;
         end
         HUNT_SECOND: begin
            if (rx == magic_b) parse_at = TAKE_VERSION;
            else if (rx != magic_a) parse_at = HUNT_FIRST;
         end
         TAKE_VERSION: begin
            if (rx != version_req) begin
               restart_parser();
            end else begin
               crc_acc  = crc8_fold(8'h00, rx);
               parse_at = TAKE_TYPE;
            end
         end
         TAKE_TYPE: begin
            hold_type = rx;
            crc_acc   = crc8_fold(crc_acc, rx);
            parse_at  = TAKE_SEQ;
         end
         TAKE_SEQ: begin
            crc_acc  = crc8_fold(crc_acc, rx);
            parse_at = TAKE_LENGTH;
         end
         TAKE_LENGTH: begin
            if (rx > LEN_LIMIT) begin
               restart_parser();
            end else begin
               hold_len   = rx[5:0];
               fill_count = 6'd0;
               crc_acc    = crc8_fold(crc_acc, rx);
               parse_at   = (rx == 8'h00) ? TAKE_CHECK : TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            payload_mem[fill_count[4:0]] = rx;
            fill_count = fill_count + 6'd1;
            crc_acc    = crc8_fold(crc_acc, rx);
            if (fill_count >= hold_len) parse_at = TAKE_CHECK;
         end
         TAKE_CHECK: begin
            if (rx == crc_acc) begin
               r.frame_type     = hold_type;
               r.payload_length = hold_len;
               if (hold_type == heartbeat_type) begin
                  r.is_heartbeat = 1'b1;
                  r.last         = 1'b1;
                  frame_results_q.push_back(r);
               end else if (hold_len == 6'd0) begin
                  r.last = 1'b1;
                  frame_results_q.push_back(r);
               end else begin
                  for (int i = 0; i < hold_len; i++) begin
                     r.byte_index   = i[4:0];
                     r.payload_byte = payload_mem[i];
                     r.has_byte     = 1'b1;
                     r.last         = (i == hold_len - 1);
                     frame_results_q.push_back(r);
                  end
               end
            end
            restart_parser();
         end
      endcase
   endtask

   // Build one frame under the current register values; len is the bad length for oversize
   function automatic void queue_frame(input logic [7:0] kind, input int len,
                                       input frame_flaw_type flaw, input int fill = -1);
      logic [7:0] crc;
      logic [7:0] data;
      tx_bytes_q.push_back(magic_a);
      tx_bytes_q.push_back(magic_b);
      if (flaw == FRAME_BAD_VERSION) begin
         tx_bytes_q.push_back(version_req ^ 8'($urandom_range(1, 255)));
         return;
      end
      tx_bytes_q.push_back(version_req);
      crc = crc8_fold(8'h00, version_req);
      tx_bytes_q.push_back(kind);
      crc = crc8_fold(crc, kind);
      data = 8'($urandom_range(0, 255));
      tx_bytes_q.push_back(data);
      crc = crc8_fold(crc, data);
      tx_bytes_q.push_back(8'(len));
      if (flaw == FRAME_OVERSIZE) return;
      crc = crc8_fold(crc, 8'(len));
      for (int i = 0; i < len; i++) begin
         data = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
         tx_bytes_q.push_back(data);
         crc = crc8_fold(crc, data);
      end
      tx_bytes_q.push_back((flaw == FRAME_BAD_CRC) ? crc ^ 8'($urandom_range(1, 255)) : crc);
   endfunction

   // Offer one request; valid stays high on return
   task automatic send_byte(input logic [7:0] rx);
      int unsigned gap;
      gap = req_no_gap ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      parse_rx_byte(rx);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic flush_bytes();
      while (tx_bytes_q.size() != 0) send_byte(tx_bytes_q.pop_front());
   endtask

   task automatic req_idle();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain_results(input int extra);
      req_idle();
      while (frame_results_q.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_FIRST_MAGIC:    magic_a = val;
         CSR_SECOND_MAGIC:   magic_b = val;
         CSR_VERSION_VALUE:  version_req = val;
         CSR_HEARTBEAT_KIND: heartbeat_type = val;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] first, input logic [7:0] second,
                                 input logic [7:0] version, input logic [7:0] heartbeat);
      drain_results(SETTLE_CYCLES);
      write_register(CSR_FIRST_MAGIC, first);
      write_register(CSR_SECOND_MAGIC, second);
      write_register(CSR_VERSION_VALUE, version);
      write_register(CSR_HEARTBEAT_KIND, heartbeat);
   endtask

   // Data, heartbeat and empty frame under the current registers
   task automatic run_settings_frames();
      queue_frame(~heartbeat_type, 2, FRAME_GOOD);
      queue_frame(heartbeat_type, 0, FRAME_GOOD);
      queue_frame(heartbeat_type ^ 8'h01, 0, FRAME_GOOD);
      flush_bytes();
      req_idle();
   endtask

   task automatic test_directed_cases();
      req_no_gap   = 1'b0;
      rsp_no_stall = 1'b0;
      // repeated first magic ahead of an empty data frame
      tx_bytes_q.push_back(magic_a);
      queue_frame(8'hFF, 0, FRAME_GOOD);
      // first magic followed by junk restarts the hunt
      tx_bytes_q.push_back(magic_a);
      tx_bytes_q.push_back(8'h3C);
      queue_frame(heartbeat_type, 1, FRAME_GOOD, 8'hFF);
      queue_frame(8'h07, 0, FRAME_BAD_VERSION);
      queue_frame(8'h07, LEN_LIMIT + 1, FRAME_OVERSIZE);
      queue_frame(8'h07, 255, FRAME_OVERSIZE);
      queue_frame(8'h12, 0, FRAME_BAD_CRC);
      flush_bytes();
      drain_results(0);
   endtask

   task automatic test_register_settings();
      apply_settings(8'h00, 8'hFF, 8'hFF, 8'hFF);
      run_settings_frames();
      apply_settings(8'hFF, 8'h00, 8'h00, 8'h00);
      run_settings_frames();
      // identical start bytes
      apply_settings(8'h5A, 8'h5A, 8'h80, 8'h7F);
      run_settings_frames();
      // writes to spare slots must change nothing
      drain_results(SETTLE_CYCLES);
      write_register(CSR_SPARE_LO, 8'($urandom_range(0, 255)));
      write_register(CSR_SPARE_HI, 8'($urandom_range(0, 255)));
      run_settings_frames();
      apply_settings(RST_FIRST_MAGIC, RST_SECOND_MAGIC, RST_VERSION_VALUE, RST_HEARTBEAT_KIND);
   endtask

   task automatic test_backpressure();
      // hold the result side long enough for the input to stall
      rsp_hold_left = 250;
      req_no_gap    = 1'b1;
      repeat (2) queue_frame(heartbeat_type ^ 8'h21, 8, FRAME_GOOD);
      flush_bytes();
      // pause the sender until everything is out
      drain_results(0);
      queue_frame(heartbeat_type ^ 8'h21, 4, FRAME_GOOD);
      flush_bytes();
      req_idle();
      req_no_gap = 1'b0;
   endtask

   task automatic test_random_traffic();
      int unsigned target;
      int unsigned next_config;
      int          pick;
      int          len;
      logic [7:0]  kind;
      target      = bytes_sent + RANDOM_BYTES;
      next_config = bytes_sent + CONFIG_SPAN;
      queue_frame(heartbeat_type ^ 8'h5C, LEN_LIMIT, FRAME_GOOD);
      flush_bytes();
      while (bytes_sent < target) begin
         if (bytes_sent >= next_config) begin
            apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            next_config = bytes_sent + CONFIG_SPAN;
         end
         req_no_gap   = ($urandom_range(0, 4) == 0);
         rsp_no_stall = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, LEN_LIMIT)
                                             : $urandom_range(0, 6);
         kind = ($urandom_range(0, 3) == 0) ? heartbeat_type : 8'($urandom_range(0, 255));
         if (pick < 65) begin
            queue_frame(kind, len, FRAME_GOOD);
         end else if (pick < 75) begin
            queue_frame(kind, len, FRAME_BAD_CRC);
         end else if (pick < 80) begin
            queue_frame(kind, len, FRAME_BAD_VERSION);
         end else if (pick < 85) begin
            queue_frame(kind, $urandom_range(LEN_LIMIT + 1, 255), FRAME_OVERSIZE);
         end else if (pick < 92) begin
            // cut a frame short
            queue_frame(kind, len, FRAME_GOOD);
            repeat ($urandom_range(1, tx_bytes_q.size() - 1)) void'(tx_bytes_q.pop_back());
         end else begin
            repeat ($urandom_range(1, 6)) begin
               tx_bytes_q.push_back(($urandom_range(0, 2) == 0) ? magic_a
                                                               : 8'($urandom_range(0, 255)));
            end
         end
         flush_bytes();
      end
      req_idle();
      req_no_gap   = 1'b0;
      rsp_no_stall = 1'b0;
   endtask

   // Drive result-side ready: long hold first, then per-result stall
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else if (rsp_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each accepted result with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_result = '{rsp_frame_type, rsp_payload_length, rsp_byte_index,
                         rsp_payload_byte, rsp_has_byte, rsp_is_heartbeat, rsp_last};
         if (frame_results_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", seen_result);
         end else begin
            want_result = frame_results_q.pop_front();
            if (seen_result.frame_type     !== want_result.frame_type     ||
                seen_result.payload_length !== want_result.payload_length ||
                seen_result.byte_index     !== want_result.byte_index     ||
                seen_result.payload_byte   !== want_result.payload_byte   ||
                seen_result.has_byte       !== want_result.has_byte       ||
                seen_result.is_heartbeat   !== want_result.is_heartbeat   ||
                seen_result.last           !== want_result.last) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result mismatch: expected %p", want_result);
                  $display("                 actual   %p", seen_result);
               end
            end
         end
         rsp_stall_left = rsp_no_stall ? 0 : $urandom_range(0, MAX_GAP);
      end
   end

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_FIRST_MAGIC;
      csr_wdata      = 8'h00;
      req_valid      = 1'b0;
      req_rx_byte    = 8'h00;
      magic_a        = RST_FIRST_MAGIC;
      magic_b        = RST_SECOND_MAGIC;
      version_req    = RST_VERSION_VALUE;
      heartbeat_type = RST_HEARTBEAT_KIND;
      restart_parser();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_register_settings();
      test_backpressure();
      test_random_traffic();

      drain_results(SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
